@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/dwg_pkg.sv @@
package dwg_pkg;

    // Field widths.
    localparam int COORD_W    = 8;
    localparam int SIZE_W     = 9;
    localparam int COUNT_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream packing.
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 40;
    localparam int OUT_COUNT_LSB = 17;
    localparam int OUT_USED_W    = 1 + COORD_W + COORD_W + COUNT_W + 1;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_USED_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [SIZE_W-1:0]  RST_GRID_WIDTH   = 9'd250;
    localparam logic [SIZE_W-1:0]  RST_GRID_HEIGHT  = 9'd250;
    localparam logic [COUNT_W-1:0] RST_TARGET_COUNT = 16'd5000;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_SPAWN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    // Step axis and direction codes.
    localparam logic AXIS_X  = 1'b0;
    localparam logic DIR_INC = 1'b0;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_WALKING   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STUCK     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OCCUPIED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_WALKER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_FINISHED  = 3'd7;

    // Grid memory operation requested by the controller.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_RD_CTR,
        OP_RD_LEFT,
        OP_RD_RIGHT,
        OP_EVAL,
        OP_SWEEP
    } dwg_op_t;

    // One input transaction, unpacked.
    typedef struct packed {
        logic               direction;
        logic               axis;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
        logic [MODE_W-1:0]  mode;
    } dwg_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    item_load;
        logic    decide;
        logic    sweep_start;
        dwg_op_t op;
        logic    out_load;
    } dwg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic decide_done;
        logic decide_clear;
        logic ctr_stop;
        logic sweep_last;
        logic out_free;
    } dwg_stat_t;

endpackage

@@ hw/rtl/dwg_ctrl.sv @@
module dwg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dwg_pkg::dwg_stat_t  stat,
    output dwg_pkg::dwg_cmd_t   cmd
);
    import dwg_pkg::*;

    typedef enum logic [3:0] {
        S_BOOT,
        S_BOOT_SWEEP,
        S_IDLE,
        S_DECIDE,
        S_RD_CTR,
        S_RD_LEFT,
        S_RD_RIGHT,
        S_EVAL,
        S_CLR_SWEEP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and the commands issued in the current state.
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.op          = OP_IDLE;
        s_tready        = 1'b0;
        case (state_reg)
            S_BOOT: begin
                cmd.sweep_start = 1'b1;
                state_next      = S_BOOT_SWEEP;
            end
            S_BOOT_SWEEP: begin
                cmd.op = OP_SWEEP;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready      = 1'b1;
                cmd.item_load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (stat.decide_clear) begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_CLR_SWEEP;
                end else if (stat.decide_done) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_RD_CTR;
                end
            end
            S_RD_CTR: begin
                cmd.op     = OP_RD_CTR;
                state_next = S_RD_LEFT;
            end
            S_RD_LEFT: begin
                cmd.op = OP_RD_LEFT;
                if (stat.ctr_stop) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_RD_RIGHT;
                end
            end
            S_RD_RIGHT: begin
                cmd.op     = OP_RD_RIGHT;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.op     = OP_EVAL;
                state_next = S_DONE;
            end
            S_CLR_SWEEP: begin
                cmd.op = OP_SWEEP;
                if (stat.sweep_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_BOOT;
            end
        endcase
    end

    // State register; reset starts the clearing pass over the grid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_BOOT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/dwg_datapath.sv @@
module dwg_datapath #(
    parameter int GRID_DIM = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dwg_pkg::dwg_cmd_t                 cmd,
    output dwg_pkg::dwg_stat_t                stat,
    input  dwg_pkg::dwg_item_t                item,
    input  logic                              cfg_we,
    input  logic [dwg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dwg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [dwg_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [dwg_pkg::STATUS_W-1:0]      m_tuser
);
    import dwg_pkg::*;

    // The grid is stored one column per word, one bit per row.
    localparam int LIM = (GRID_DIM < 256) ? GRID_DIM : 256;
    localparam int CW  = $clog2(LIM);
    localparam logic [SIZE_W-1:0] LIM_SIZE  = SIZE_W'(LIM);
    localparam logic [CW-1:0]     LAST_WORD = CW'(LIM - 1);

    typedef logic [LIM-1:0] row_t;

    row_t grid_mem [LIM];
    row_t mem_rdata_reg;
    row_t row_c_reg;
    row_t mem_wdata;
    logic [CW-1:0] mem_addr;
    logic mem_we;
    logic mem_re;

    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [COUNT_W-1:0]  target_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [COORD_W-1:0]  px_reg;
    logic [COORD_W-1:0]  py_reg;
    logic                axis_reg;
    logic                dir_reg;
    logic [COORD_W-1:0]  cx_reg;
    logic [COORD_W-1:0]  cy_reg;
    logic [COORD_W-1:0]  walker_x_reg;
    logic [COORD_W-1:0]  walker_y_reg;
    logic                active_reg;
    logic [COUNT_W-1:0]  stuck_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                cell_reg;
    logic                left_reg;
    logic [CW-1:0]       sweep_cnt_reg;
    logic [CW-1:0]       seed_x_reg;
    logic [CW-1:0]       seed_y_reg;
    logic                m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic [SIZE_W-1:0]  w_eff;
    logic [SIZE_W-1:0]  h_eff;
    logic [SIZE_W-1:0]  w_m1;
    logic [SIZE_W-1:0]  h_m1;
    logic               finished;
    logic               pos_out;
    logic [COORD_W-1:0] col_cl;
    logic [COORD_W-1:0] row_cl;
    logic [COORD_W-1:0] col_mv;
    logic [COORD_W-1:0] row_mv;
    logic [CW-1:0]      cx_a;
    logic [CW-1:0]      cy_a;
    logic [CW-1:0]      cy_dn;
    logic [CW-1:0]      cy_up;
    logic               x_lo_ok;
    logic               x_hi_ok;
    logic               y_lo_ok;
    logic               y_hi_ok;
    logic               ctr_bit;
    logic               touch;

    // Grid size in use: zero acts as one, oversize is cut to the grid.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = SIZE_W'(1);
        end else if (width_reg > LIM_SIZE) begin
            w_eff = LIM_SIZE;
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = SIZE_W'(1);
        end else if (height_reg > LIM_SIZE) begin
            h_eff = LIM_SIZE;
        end else begin
            h_eff = height_reg;
        end
    end

    assign w_m1     = w_eff - SIZE_W'(1);
    assign h_m1     = h_eff - SIZE_W'(1);
    assign finished = (stuck_reg >= target_reg);
    assign pos_out  = ({1'b0, px_reg} >= w_eff) || ({1'b0, py_reg} >= h_eff);

    // Walker clamped into the grid in use, then moved one cell.
    assign col_cl = ({1'b0, walker_x_reg} >= w_eff) ? w_m1[COORD_W-1:0] : walker_x_reg;
    assign row_cl = ({1'b0, walker_y_reg} >= h_eff) ? h_m1[COORD_W-1:0] : walker_y_reg;

    always_comb begin
        col_mv = col_cl;
        row_mv = row_cl;
        if (axis_reg == AXIS_X) begin
            if (dir_reg == DIR_INC) begin
                if (({1'b0, col_cl} + SIZE_W'(1)) < w_eff) begin
                    col_mv = col_cl + COORD_W'(1);
                end
            end else if (col_cl != '0) begin
                col_mv = col_cl - COORD_W'(1);
            end
        end else begin
            if (dir_reg == DIR_INC) begin
                if (({1'b0, row_cl} + SIZE_W'(1)) < h_eff) begin
                    row_mv = row_cl + COORD_W'(1);
                end
            end else if (row_cl != '0) begin
                row_mv = row_cl - COORD_W'(1);
            end
        end
    end

    // Neighbour positions of the working cell and whether they lie inside the grid.
    assign cx_a    = cx_reg[CW-1:0];
    assign cy_a    = cy_reg[CW-1:0];
    assign x_lo_ok = (cx_reg != '0);
    assign y_lo_ok = (cy_reg != '0);
    assign x_hi_ok = (({1'b0, cx_reg} + SIZE_W'(1)) < w_eff);
    assign y_hi_ok = (({1'b0, cy_reg} + SIZE_W'(1)) < h_eff);
    assign cy_dn   = y_lo_ok ? (cy_a - CW'(1)) : cy_a;
    assign cy_up   = y_hi_ok ? (cy_a + CW'(1)) : cy_a;
    assign ctr_bit = mem_rdata_reg[cy_a];

    // The right-hand column word arrives during the evaluation cycle.
    assign touch = (x_lo_ok & left_reg) | (x_hi_ok & mem_rdata_reg[cy_a]) |
                   (y_lo_ok & row_c_reg[cy_dn]) | (y_hi_ok & row_c_reg[cy_up]);

    // Status back to the controller.
    always_comb begin
        stat.decide_clear = (mode_reg == MODE_CLEAR);
        stat.decide_done  = ((mode_reg == MODE_SPAWN) && (finished || pos_out)) ||
                            ((mode_reg == MODE_STEP) && !active_reg) ||
                            ((mode_reg == MODE_READ) && pos_out);
        stat.ctr_stop     = (mode_reg == MODE_READ) ||
                            ((mode_reg == MODE_SPAWN) && ctr_bit);
        stat.sweep_last   = (sweep_cnt_reg == LAST_WORD);
        stat.out_free     = !m_valid_reg || m_tready;
    end

    // Address and data of the single grid memory port.
    always_comb begin
        mem_addr  = cx_a;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = row_c_reg | (row_t'(1) << cy_a);
        case (cmd.op)
            OP_RD_CTR: begin
                mem_re = 1'b1;
            end
            OP_RD_LEFT: begin
                mem_re   = 1'b1;
                mem_addr = x_lo_ok ? (cx_a - CW'(1)) : cx_a;
            end
            OP_RD_RIGHT: begin
                mem_re   = 1'b1;
                mem_addr = x_hi_ok ? (cx_a + CW'(1)) : cx_a;
            end
            OP_EVAL: begin
                mem_we = touch;
            end
            OP_SWEEP: begin
                mem_addr  = sweep_cnt_reg;
                mem_we    = 1'b1;
                mem_wdata = (sweep_cnt_reg == seed_x_reg) ? (row_t'(1) << seed_y_reg) : '0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Grid memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            mem_rdata_reg <= grid_mem[mem_addr];
        end
    end

    // Configuration registers, walker, stuck count and sweep counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= RST_GRID_WIDTH;
            height_reg    <= RST_GRID_HEIGHT;
            target_reg    <= RST_TARGET_COUNT;
            walker_x_reg  <= '0;
            walker_y_reg  <= '0;
            active_reg    <= 1'b0;
            stuck_reg     <= '0;
            sweep_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GRID_WIDTH:   width_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_GRID_HEIGHT:  height_reg <= cfg_data[SIZE_W-1:0];
                    CFG_TARGET_COUNT: target_reg <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.sweep_start) begin
                sweep_cnt_reg <= '0;
            end else if (cmd.op == OP_SWEEP && !stat.sweep_last) begin
                sweep_cnt_reg <= sweep_cnt_reg + CW'(1);
            end
            if (cmd.decide) begin
                if (mode_reg == MODE_STEP && active_reg) begin
                    walker_x_reg <= col_mv;
                    walker_y_reg <= row_mv;
                end else if (mode_reg == MODE_CLEAR) begin
                    stuck_reg  <= '0;
                    active_reg <= 1'b0;
                end
            end
            if (cmd.op == OP_RD_LEFT && mode_reg == MODE_SPAWN && !ctr_bit) begin
                walker_x_reg <= cx_reg;
                walker_y_reg <= cy_reg;
                active_reg   <= 1'b1;
            end
            if (cmd.op == OP_EVAL && touch) begin
                active_reg <= 1'b0;
                if (stuck_reg != COUNT_MAX) begin
                    stuck_reg <= stuck_reg + COUNT_W'(1);
                end
            end
        end
    end

    // Item fields, working position and the status of the transaction.
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            mode_reg <= item.mode;
            px_reg   <= item.pos_x;
            py_reg   <= item.pos_y;
            axis_reg <= item.axis;
            dir_reg  <= item.direction;
        end
        if (cmd.sweep_start) begin
            seed_x_reg <= w_eff[CW:1];
            seed_y_reg <= h_eff[CW:1];
        end
        if (cmd.decide) begin
            cell_reg <= 1'b0;
            case (mode_reg)
                MODE_SPAWN: begin
                    cx_reg <= px_reg;
                    cy_reg <= py_reg;
                    if (finished) begin
                        status_reg <= ST_FINISHED;
                    end else if (pos_out) begin
                        status_reg <= ST_RANGE;
                    end
                end
                MODE_STEP: begin
                    cx_reg <= col_mv;
                    cy_reg <= row_mv;
                    if (!active_reg) begin
                        status_reg <= ST_NO_WALKER;
                    end
                end
                MODE_READ: begin
                    cx_reg <= px_reg;
                    cy_reg <= py_reg;
                    if (pos_out) begin
                        status_reg <= ST_RANGE;
                    end
                end
                default: begin
                    status_reg <= ST_CLEARED;
                end
            endcase
        end
        if (cmd.op == OP_RD_LEFT) begin
            row_c_reg <= mem_rdata_reg;
            if (mode_reg == MODE_READ) begin
                cell_reg   <= ctr_bit;
                status_reg <= ST_READ;
            end else if (ctr_bit) begin
                status_reg <= ST_OCCUPIED;
            end
        end
        if (cmd.op == OP_RD_RIGHT) begin
            left_reg <= ctr_bit;
        end
        if (cmd.op == OP_EVAL) begin
            status_reg <= touch ? ST_STUCK : ST_WALKING;
        end
    end

    // Output register; it frees the input side while a result waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tuser_reg <= status_reg;
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, finished, stuck_reg,
                            walker_y_reg, walker_x_reg, cell_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ hw/rtl/dla_walker_grid_unit.sv @@
// Path: a refused spawn or step goes from decide to the result; a read or occupied spawn reads
// centre and left columns; a spawn or step reads centre, left, right and evaluates. A clear
// sweeps all GRID_DIM (at most 256) columns. One item at a time: the next is taken in the cycle
// after its result is registered. The single-port grid memory, one column per word, sets the
// step cost: three reads, at most one write. Reset (aresetn low, synchronous) clears control
// state, then sweeps the grid one column a cycle, seeding the centre; no item taken meanwhile.
`include "assert_macros.svh"

module dla_walker_grid_unit #(
    parameter int GRID_DIM = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: pos_x_in [7:0], pos_y_in [15:8], axis [16], direction [17], zero [23:18]
    input  logic [dwg_pkg::IN_TDATA_W-1:0]     s_tdata,
    // tuser: mode [1:0]
    input  logic [dwg_pkg::MODE_W-1:0]         s_tuser,
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: cell_value [0], walker_x_out [8:1], walker_y_out [16:9],
    //        particles_stuck [32:17], run_done [33], zero [39:34]
    output logic [dwg_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // tuser: status [2:0]
    output logic [dwg_pkg::STATUS_W-1:0]       m_tuser,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dwg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dwg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dwg_pkg::*;

    dwg_cmd_t  cmd;
    dwg_stat_t stat;
    dwg_item_t item;

    // Registers can be written in any cycle.
    assign cfg_ready = 1'b1;

    // Unpack the input transaction.
    assign item.mode      = s_tuser;
    assign item.pos_x     = s_tdata[7:0];
    assign item.pos_y     = s_tdata[15:8];
    assign item.axis      = s_tdata[16];
    assign item.direction = s_tdata[17];

    dwg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dwg_datapath #(
        .GRID_DIM (GRID_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Only one item is in work: accepting one closes the input side.
    `ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A result is never loaded over one that has not been taken.
    `ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_tvalid || m_tready)
    // A clear always reports a stuck count of zero.
    `ASSERT_IMPL(a_clear_count, aclk, aresetn, m_tvalid && (m_tuser == ST_CLEARED), m_tdata[OUT_COUNT_LSB +: COUNT_W] == '0)

endmodule
